FILE: src/swiglu_pkg.sv
package swiglu_pkg;

  localparam int MAX_LANES = 4;
  localparam int VAL_W = 16;
  localparam int PROD_W = 32;
  localparam int MASK_W = 4;
  localparam int DATA_IN_W = 2 * MAX_LANES * VAL_W;
  localparam int DATA_OUT_W = MAX_LANES * PROD_W;

  localparam int LANES_DEF = 4;
  localparam int SIGMOID_FRAC_DEF = 16;

  localparam int T_W = 46;
  localparam int EXP_W = 8;
  localparam int Y_W = 30;
  localparam int P_W = 31;
  localparam int DEN_W = 32;
  localparam int DIV_BITS = 31;
  localparam int RECIP_SHIFT = 60;
  localparam int EXP_LIMIT = 31;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [P_W-1:0] ONE_Q30 = 31'd1 << 30;

  localparam int HORNER_TERMS = 8;
  localparam int HORNER_STAGES = 3;
  localparam int HORNER_LAT = HORNER_TERMS * HORNER_STAGES;

  localparam int LANE_LAT = 2 + HORNER_LAT + 1 + DIV_BITS + 4;

  typedef struct packed {
    logic [EXP_W-1:0] n;
    logic signed [VAL_W-1:0] g;
    logic signed [VAL_W-1:0] u;
  } side_t;

  typedef struct packed {
    logic [MAX_LANES-1:0][PROD_W-1:0] prod;
    logic [MASK_W-1:0] mask;
    logic last;
  } res_t;

endpackage

FILE: src/swiglu_horner_step.sv
module swiglu_horner_step #(
  parameter int K = 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [swiglu_pkg::Y_W-1:0] y_in,
  input  logic [swiglu_pkg::P_W-1:0] p_in,
  output logic [swiglu_pkg::Y_W-1:0] y_out,
  output logic [swiglu_pkg::P_W-1:0] p_out
);
  import swiglu_pkg::*;

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

  logic [59:0] yp;
  logic [Y_W-1:0] y_a, v_a;
  logic [61:0] vm;
  logic [Y_W-1:0] y_b, v_b, qe_b;
  logic [33:0] qk;
  logic [33:0] rem;
  logic [Y_W-1:0] quo;

  assign yp = 60'(y_in) * 60'(p_in);
  assign vm = 62'(v_a) * 62'(RECIP);
  assign qk = 34'(qe_b) * 34'(K);
  assign rem = 34'(v_b) - qk;
  assign quo = (rem >= 34'(K)) ? (qe_b + 30'd1) : qe_b;

  always_ff @(posedge clk) begin
    if (en) begin
      y_a <= y_in;
      v_a <= yp[59:30];
      y_b <= y_a;
      v_b <= v_a;
      qe_b <= vm[61:32];
      y_out <= y_b;
      p_out <= ONE_Q30 - P_W'(quo);
    end
  end

endmodule

FILE: src/swiglu_recip_div.sv
module swiglu_recip_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [swiglu_pkg::DEN_W-1:0] den,
  output logic [swiglu_pkg::DIV_BITS-1:0] quo
);
  import swiglu_pkg::*;

  localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(64'd1 << (RECIP_SHIFT - DIV_BITS));

  logic [DEN_W-1:0] rem [DIV_BITS];
  logic [DEN_W-1:0] dens [DIV_BITS];
  logic [DIV_BITS-1:0] quos [DIV_BITS];

  for (genvar gi = 0; gi < DIV_BITS; gi++) begin : g_bit
    logic [DEN_W-1:0] rem_cur, den_cur, rem_sh;
    logic [DIV_BITS-1:0] quo_cur, quo_next;
    logic fits;

    if (gi == 0) begin : g_first
      assign rem_cur = REM_INIT;
      assign den_cur = den;
      assign quo_cur = '0;
    end else begin : g_rest
      assign rem_cur = rem[gi-1];
      assign den_cur = dens[gi-1];
      assign quo_cur = quos[gi-1];
    end

    assign rem_sh = {rem_cur[DEN_W-2:0], 1'b0};
    assign fits = (rem_sh >= den_cur);

    always_comb begin
      quo_next = quo_cur;
      quo_next[DIV_BITS-1-gi] = fits;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[gi] <= fits ? (rem_sh - den_cur) : rem_sh;
        dens[gi] <= den_cur;
        quos[gi] <= quo_next;
      end
    end
  end

  assign quo = quos[DIV_BITS-1];

endmodule

FILE: src/swiglu_lane.sv
module swiglu_lane #(
  parameter int SIGMOID_FRAC = swiglu_pkg::SIGMOID_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [swiglu_pkg::VAL_W-1:0]  gate,
  input  logic signed [swiglu_pkg::VAL_W-1:0]  up,
  output logic signed [swiglu_pkg::PROD_W-1:0] prod
);
  import swiglu_pkg::*;

  localparam int SIG_W = SIGMOID_FRAC + 1;
  localparam int GS_W = SIGMOID_FRAC + 18;
  localparam int SIDE_D = HORNER_LAT + 1 + DIV_BITS;
  localparam logic [P_W-1:0] ROUND_HALF = P_W'(64'd1 << (29 - SIGMOID_FRAC));
  localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(64'd1 << SIGMOID_FRAC);
  localparam logic signed [GS_W-1:0] SILU_HALF = GS_W'(64'd1 << (SIGMOID_FRAC - 1));

  logic [VAL_W-1:0] mag;
  logic [T_W-1:0] t1;
  logic signed [VAL_W-1:0] g1, u1;
  logic [59:0] fy;
  logic [Y_W-1:0] y2;
  side_t side2;
  side_t side [SIDE_D];

  wire [Y_W-1:0] y_h [HORNER_TERMS+1];
  wire [P_W-1:0] p_h [HORNER_TERMS+1];

  logic [P_W-1:0] e_val;
  logic [DEN_W-1:0] den;
  logic [DIV_BITS-1:0] s_div;
  logic [P_W-1:0] s_sum;
  logic [SIG_W-1:0] r_val;
  logic [SIG_W-1:0] sig;
  logic signed [VAL_W-1:0] g_r, u_r;
  logic signed [GS_W-1:0] g_ext, sig_ext;
  logic signed [GS_W-1:0] gs;
  logic signed [VAL_W-1:0] u_m;
  logic signed [GS_W-1:0] gs_sum;
  logic signed [VAL_W-1:0] silu, u_s;

  assign mag = gate[VAL_W-1] ? (~gate + 16'd1) : gate;
  assign fy = 60'(t1[37:8]) * 60'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= T_W'(mag) * T_W'(LOG2E_Q30);
      g1 <= gate;
      u1 <= up;
      y2 <= fy[59:30];
      side2.n <= t1[T_W-1:38];
      side2.g <= g1;
      side2.u <= u1;
      side[0] <= side2;
      for (int i = 1; i < SIDE_D; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign y_h[0] = y2;
  assign p_h[0] = ONE_Q30;

  for (genvar gj = 0; gj < HORNER_TERMS; gj++) begin : g_horner
    swiglu_horner_step #(
      .K(HORNER_TERMS - gj)
    ) u_step (
      .clk  (clk),
      .en   (en),
      .y_in (y_h[gj]),
      .p_in (p_h[gj]),
      .y_out(y_h[gj+1]),
      .p_out(p_h[gj+1])
    );
  end

  assign e_val = (side[HORNER_LAT-1].n >= EXP_W'(EXP_LIMIT)) ? '0
               : (p_h[HORNER_TERMS] >> side[HORNER_LAT-1].n[4:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      den <= DEN_W'(ONE_Q30) + DEN_W'(e_val);
    end
  end

  swiglu_recip_div u_div (
    .clk(clk),
    .en (en),
    .den(den),
    .quo(s_div)
  );

  assign s_sum = P_W'(s_div) + ROUND_HALF;
  assign r_val = s_sum[P_W-1 -: SIG_W];
  assign g_ext = GS_W'(g_r);
  assign sig_ext = GS_W'($signed({1'b0, sig}));
  assign gs_sum = gs + SILU_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      sig <= side[SIDE_D-1].g[VAL_W-1] ? (SIG_ONE - r_val) : r_val;
      g_r <= side[SIDE_D-1].g;
      u_r <= side[SIDE_D-1].u;
      gs <= g_ext * sig_ext;
      u_m <= u_r;
      silu <= gs_sum[SIGMOID_FRAC+VAL_W-1:SIGMOID_FRAC];
      u_s <= u_m;
      prod <= PROD_W'(silu) * PROD_W'(u_s);
    end
  end

endmodule

FILE: src/swiglu_out_queue.sv
module swiglu_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swiglu_pkg::res_t  push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output swiglu_pkg::res_t  out_data
);
  import swiglu_pkg::*;

  logic head_vld, skid_vld;
  logic head_vld_next, skid_vld_next;
  logic pop, load_head, load_skid, move_skid;
  res_t skid;

  assign pop = head_vld & out_ready;
  assign space = ~skid_vld;
  assign out_valid = head_vld;

  always_comb begin
    head_vld_next = head_vld;
    skid_vld_next = skid_vld;
    load_head = 1'b0;
    load_skid = 1'b0;
    move_skid = 1'b0;
    if (skid_vld) begin
      if (pop) begin
        move_skid = 1'b1;
        skid_vld_next = 1'b0;
      end
    end else if (!head_vld || pop) begin
      head_vld_next = push;
      load_head = push;
    end else if (push) begin
      skid_vld_next = 1'b1;
      load_skid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      head_vld <= head_vld_next;
      skid_vld <= skid_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      out_data <= skid;
    end else if (load_head) begin
      out_data <= push_data;
    end
    if (load_skid) begin
      skid <= push_data;
    end
  end

endmodule

FILE: src/swiglu_gate_multiply_core.sv
// Channel  Direction  Data                                   Side fields
// s_       in         gate_0..3, up_0..3 (16 bits each)      tuser lane_mask, tlast last
// m_       out        prod_0..3 (32 bits each)               tuser valid_lanes, tlast last_out
//
// One request is taken every cycle while the output buffer has space.
// The pipeline holds the 24-stage Horner series for the exponential and the
// 31-stage restoring divider that forms the sigmoid, one quotient bit per stage.
// Reset clears the valid bits and the output buffer; s_tready is high the cycle after.
// The whole pipeline holds still only while both output buffer entries are full.
module swiglu_gate_multiply_core #(
  parameter int LANES = swiglu_pkg::LANES_DEF,
  parameter int SIGMOID_FRAC = swiglu_pkg::SIGMOID_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // gate_0, gate_1, gate_2, gate_3, up_0, up_1, up_2, up_3
  input  logic [swiglu_pkg::DATA_IN_W-1:0]     s_tdata,
  // lane_mask
  input  logic [swiglu_pkg::MASK_W-1:0]        s_tuser,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // prod_0, prod_1, prod_2, prod_3
  output logic [swiglu_pkg::DATA_OUT_W-1:0]    m_tdata,
  // valid_lanes
  output logic [swiglu_pkg::MASK_W-1:0]        m_tuser,
  output logic                                 m_tlast
);
  import swiglu_pkg::*;

  localparam logic [MASK_W-1:0] LANE_MASK = MASK_W'((1 << LANES) - 1);

  logic en;
  logic [LANE_LAT-1:0] vld;
  logic [LANE_LAT-1:0][MASK_W-1:0] mask_d;
  logic [LANE_LAT-1:0] last_d;
  logic [MAX_LANES-1:0][PROD_W-1:0] lane_prod;
  res_t merged, res_out;

  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask_d <= {mask_d[LANE_LAT-2:0], s_tuser & LANE_MASK};
      last_d <= {last_d[LANE_LAT-2:0], s_tlast};
    end
  end

  for (genvar gl = 0; gl < MAX_LANES; gl++) begin : g_lane
    if (gl < LANES) begin : g_on
      swiglu_lane #(
        .SIGMOID_FRAC(SIGMOID_FRAC)
      ) u_lane (
        .clk (clk),
        .en  (en),
        .gate(s_tdata[gl*VAL_W +: VAL_W]),
        .up  (s_tdata[(MAX_LANES+gl)*VAL_W +: VAL_W]),
        .prod(lane_prod[gl])
      );
    end else begin : g_off
      assign lane_prod[gl] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      merged.prod[i] = mask_d[LANE_LAT-1][i] ? lane_prod[i] : '0;
    end
    merged.mask = mask_d[LANE_LAT-1];
    merged.last = last_d[LANE_LAT-1];
  end

  swiglu_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (en & vld[LANE_LAT-1]),
    .push_data(merged),
    .space    (en),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (res_out)
  );

  assign m_tdata = res_out.prod;
  assign m_tuser = res_out.mask;
  assign m_tlast = res_out.last;

endmodule

FILE: src/swiglu_checker.sv
module swiglu_checker #(
  parameter int LANES = swiglu_pkg::LANES_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [swiglu_pkg::DATA_OUT_W-1:0] m_tdata,
  input logic [swiglu_pkg::MASK_W-1:0]     m_tuser,
  input logic                              m_tlast
);
  import swiglu_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("Result request withdrawn while stalled.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("Result request changed while stalled.");

  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tdata[31:0] == 32'd0)
              && (m_tuser[1] || m_tdata[63:32] == 32'd0)
              && (m_tuser[2] || m_tdata[95:64] == 32'd0)
              && (m_tuser[3] || m_tdata[127:96] == 32'd0))
    else $error("Masked lane carries a non-zero product.");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser >> LANES) == '0)
    else $error("Valid lane reported beyond the built lanes.");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("Reset did not empty the output.");

endmodule

bind swiglu_gate_multiply_core swiglu_checker #(.LANES(LANES)) u_checker (.*);

FILE: bench/testbench.sv
module testbench;

  localparam int LANE_COUNT = swiglu_pkg::LANES_DEF;
  localparam int SIG_FRAC = swiglu_pkg::SIGMOID_FRAC_DEF;
  localparam logic [3:0] LANE_LIMIT = 4'((1 << LANE_COUNT) - 1);
  localparam logic [63:0] LOG2E_FIX = 64'd1549082005;
  localparam logic [63:0] LN2_FIX = 64'd744261118;
  localparam logic [63:0] ONE_FIX = 64'd1 << 30;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 470;

  typedef swiglu_pkg::res_t gated_res_t;

  typedef struct {
    logic [swiglu_pkg::DATA_IN_W-1:0] data;
    logic [3:0] mask;
    logic last;
    bit typed;
    gated_res_t known;
  } request_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [swiglu_pkg::DATA_IN_W-1:0] s_tdata;
  logic [swiglu_pkg::MASK_W-1:0] s_tuser;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [swiglu_pkg::DATA_OUT_W-1:0] m_tdata;
  logic [swiglu_pkg::MASK_W-1:0] m_tuser;
  logic m_tlast;

  gated_res_t expected_products[$];
  request_row_t directed_rows[$];
  int accepted_count = 0;
  int error_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit row_typed = 1'b0;
  gated_res_t row_known = '0;

  swiglu_gate_multiply_core #(
    .LANES(LANE_COUNT),
    .SIGMOID_FRAC(SIG_FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sigmoid of a non-negative Q8.8 magnitude, returned in Q(SIG_FRAC).
  function automatic logic [63:0] sigmoid_of_mag(input int mag);
    logic [63:0] t, n, f, y, p, e, s;
    int k;
    t = 64'(mag) * LOG2E_FIX;
    n = t >> 38;
    f = (t & ((64'd1 << 38) - 64'd1)) >> 8;
    y = (f * LN2_FIX) >> 30;
    p = ONE_FIX;
    for (k = 8; k >= 1; k--) begin
      p = ONE_FIX - ((y * p) >> 30) / 64'(k);
    end
    e = (n >= 64'd31) ? 64'd0 : (p >> n);
    s = (64'd1 << 60) / (ONE_FIX + e);
    return (s + (64'd1 << (29 - SIG_FRAC))) >> (30 - SIG_FRAC);
  endfunction

  function automatic int silu_q88(input int g);
    int mag;
    logic [63:0] r;
    longint sig, acc;
    mag = (g < 0) ? -g : g;
    r = sigmoid_of_mag(mag);
    sig = (g < 0) ? (longint'(1) << SIG_FRAC) - longint'(r) : longint'(r);
    acc = longint'(g) * sig + (longint'(1) << (SIG_FRAC - 1));
    return int'(acc >>> SIG_FRAC);
  endfunction

  function automatic gated_res_t gated_product(input logic [swiglu_pkg::DATA_IN_W-1:0] data,
                                               input logic [3:0] mask, input logic last);
    gated_res_t r;
    int lane, g_val, u_val;
    r.prod = '0;
    r.mask = mask & LANE_LIMIT;
    r.last = last;
    for (lane = 0; lane < swiglu_pkg::MAX_LANES; lane++) begin
      if (r.mask[lane]) begin
        g_val = $signed(data[16*lane +: 16]);
        u_val = $signed(data[64 + 16*lane +: 16]);
        r.prod[lane] = 32'(silu_q88(g_val) * u_val);
      end
    end
    return r;
  endfunction

  task automatic add_row(input int g0, g1, g2, g3, u0, u1, u2, u3, input logic [3:0] mask,
                         input logic last, input bit typed,
                         input int p0 = 0, p1 = 0, p2 = 0, p3 = 0);
    request_row_t row;
    row.data = {16'(u3), 16'(u2), 16'(u1), 16'(u0), 16'(g3), 16'(g2), 16'(g1), 16'(g0)};
    row.mask = mask;
    row.last = last;
    row.typed = typed;
    row.known.prod = {32'(p3), 32'(p2), 32'(p1), 32'(p0)};
    row.known.mask = mask & LANE_LIMIT;
    row.known.last = last;
    directed_rows.push_back(row);
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    gated_res_t want, got;
    int lane;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        accepted_count++;
        expected_products.push_back(row_typed ? row_known
                                              : gated_product(s_tdata, s_tuser, s_tlast));
      end
      if (m_tvalid && m_tready) begin
        got.prod = m_tdata;
        got.mask = m_tuser;
        got.last = m_tlast;
        if (expected_products.size() == 0) begin
          report("unexpected result, prod_0", '0, got.prod[0]);
        end else begin
          want = expected_products.pop_front();
          for (lane = 0; lane < swiglu_pkg::MAX_LANES; lane++) begin
            if (got.prod[lane] !== want.prod[lane])
              report($sformatf("prod_%0d", lane), want.prod[lane], got.prod[lane]);
          end
          if (got.mask !== want.mask) report("valid_lanes", 32'(want.mask), 32'(got.mask));
          if (got.last !== want.last) report("last_out", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  // The receiver holds off for a long stretch whenever the stimulus asks for it.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_request(input logic [swiglu_pkg::DATA_IN_W-1:0] data,
                              input logic [3:0] mask, input logic last,
                              input bit typed, input gated_res_t known);
    int target;
    s_tdata <= data;
    s_tuser <= mask;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    row_typed <= typed;
    row_known <= known;
    target = accepted_count + 1;
    do @(negedge clk); while (accepted_count < target);
  endtask

  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_products.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_gate();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      4, 5, 6: return 16'($signed($urandom_range(4095)) - 2048);
      7: return 16'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(5400, 5600)));
      8: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [swiglu_pkg::DATA_IN_W-1:0] data;
    logic [3:0] mask;
    int i, lane, vec_left;
    vec_left = 0;
    for (i = 0; i < count; i++) begin
      if (vec_left == 0) vec_left = $urandom_range(1, 16);
      for (lane = 0; lane < swiglu_pkg::MAX_LANES; lane++) begin
        data[16*lane +: 16] = pick_gate();
        data[64 + 16*lane +: 16] = ($urandom_range(3) == 0) ? 16'($signed($urandom_range(1023)) - 512)
                                                            : 16'($urandom);
      end
      mask = ($urandom_range(99) < 85) ? 4'hf : 4'($urandom);
      sender_gap();
      send_request(data, mask, vec_left == 1, 1'b0, '0);
      vec_left--;
    end
  endtask

  initial begin
    #(12 * 200000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;

    add_row(0, 0, 0, 0, 32767, -32768, 1, -1, 4'hf, 1'b0, 1'b1);
    add_row(1000, -1000, 32767, -32768, 500, -500, 32767, -32768, 4'h0, 1'b1, 1'b1);
    add_row(32767, -32768, 32767, -32768, 256, 32767, -32768, -32768, 4'hf, 1'b0, 1'b1,
            8388352, 0, -1073709056, 0);
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 4'hf, 1'b1, 1'b1,
            1073676289, 1073676289, 1073676289, 1073676289);
    add_row(12345, -23456, 7000, -9000, 0, 0, 0, 0, 4'hf, 1'b0, 1'b1);
    add_row(-32768, -32768, -32768, -32768, 32767, -32768, 1, -1, 4'hf, 1'b0, 1'b1);
    add_row(1, -1, 256, -256, 256, 256, 256, 256, 4'hf, 1'b0, 1'b0);
    add_row(128, -128, 512, -512, -256, 1000, -32768, 32767, 4'hf, 1'b0, 1'b0);
    add_row(5500, 5501, -5500, -5501, 32767, 32767, -32768, -32768, 4'hf, 1'b0, 1'b0);
    add_row(-1, -1, -1, -1, -1, -1, -1, -1, 4'hf, 1'b1, 1'b0);
    add_row(700, -700, 3000, -3000, 1234, -1234, 4321, -4321, 4'h1, 1'b0, 1'b0);
    add_row(700, -700, 3000, -3000, 1234, -1234, 4321, -4321, 4'h2, 1'b0, 1'b0);
    add_row(700, -700, 3000, -3000, 1234, -1234, 4321, -4321, 4'h4, 1'b0, 1'b0);
    add_row(700, -700, 3000, -3000, 1234, -1234, 4321, -4321, 4'h8, 1'b1, 1'b0);
    add_row(2048, -2048, 4096, -4096, 300, -300, 30000, -30000, 4'h5, 1'b0, 1'b0);
    add_row(2048, -2048, 4096, -4096, 300, -300, 30000, -30000, 4'ha, 1'b1, 1'b0);
    add_row(21845, -21846, 10922, -10923, 21845, -21846, 10922, -10923, 4'hf, 1'b1, 1'b0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 13;
    rx_idle_pct = 81;
    for (i = 0; i < directed_rows.size(); i++) begin
      sender_gap();
      send_request(directed_rows[i].data, directed_rows[i].mask, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].known);
    end
    run_random(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    wait_drained();
    tx_idle_pct = 81;
    rx_idle_pct = 13;
    run_random(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    run_random(PHASE_ITEMS);

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: swiglu_gate_multiply_core.f
src/swiglu_pkg.sv
src/swiglu_horner_step.sv
src/swiglu_recip_div.sv
src/swiglu_lane.sv
src/swiglu_out_queue.sv
src/swiglu_gate_multiply_core.sv
src/swiglu_checker.sv
bench/testbench.sv
